// ===== hw/rtl/pmfa_pkg.sv =====
package pmfa_pkg;

	// Default geometry
	localparam int PROCESS_SLOTS_DEF     = 16;
	localparam int PAGES_PER_PROCESS_DEF = 1024;
	localparam int USABLE_FRAMES_DEF     = 4096;
	localparam int PAGE_BYTES_DEF        = 4096;

	// Fixed field widths
	localparam int FUNC_W   = 3;
	localparam int PID_W    = 4;
	localparam int VADDR_W  = 22;
	localparam int COUNT_W  = 11;
	localparam int PROT_W   = 3;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;
	localparam int PHYS_W   = 28;
	localparam int FRAME_W  = 16;
	localparam int PTE_W    = 20;
	localparam int BOUND_W  = 14;

	localparam logic [FRAME_W-1:0] FRAME_BASE_RST = 16'd18432;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_CREATE  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_EXIT    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEALLOC = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;
	localparam logic [FUNC_W-1:0] FN_WRITE   = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STS_SEGV   = 2'd1;
	localparam logic [STATUS_W-1:0] STS_NOSLOT = 2'd2;
	localparam logic [STATUS_W-1:0] STS_NOMEM  = 2'd3;

	// Page protection flags
	localparam logic [PROT_W-1:0] FLAG_CODE = 3'd5;
	localparam logic [PROT_W-1:0] FLAG_RO   = 3'd1;
	localparam logic [PROT_W-1:0] FLAG_RW   = 3'd3;
	localparam logic [PROT_W-1:0] FLAG_R    = 3'd1;
	localparam logic [PROT_W-1:0] FLAG_W    = 3'd2;

	typedef struct packed {
		logic                latch;
		logic                clr_step;
		logic                walk_kill;
		logic                walk_range;
		logic                seg_first;
		logic                seg_next;
		logic                pt_rd;
		logic                pt_zero;
		logic                map_wr;
		logic                bm_rd_cur;
		logic                bm_rd_idx;
		logic                bm_clr;
		logic                cursor_zero;
		logic                cursor_inc;
		logic                walk_inc;
		logic                claim;
		logic                kill;
		logic                cnt_sub;
		logic                set_status;
		logic [STATUS_W-1:0] status_code;
		logic                set_access;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              have;
		logic              clr_last;
		logic              walk_done;
		logic              seg_last;
		logic              slot_free;
		logic              too_big;
		logic              frames_ok;
		logic              range_bad;
		logic              page_ok;
		logic              pte_present;
		logic              perm_ok;
		logic              idx_ok;
		logic              bm_bit;
		logic              out_busy;
	} sts_t;

endpackage

// ===== hw/rtl/pmfa_ctrl.sv =====
module pmfa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  pmfa_pkg::sts_t sts,
	output pmfa_pkg::cmd_t cmd
);

	typedef enum logic [12:0] {
		ST_CLEAR    = 13'b0000000000001,
		ST_IDLE     = 13'b0000000000010,
		ST_DISP     = 13'b0000000000100,
		ST_CHK_RD   = 13'b0000000001000,
		ST_CHK_EVAL = 13'b0000000010000,
		ST_MAP_RD   = 13'b0000000100000,
		ST_MAP_EVAL = 13'b0000001000000,
		ST_REL_RD   = 13'b0000010000000,
		ST_REL_PTE  = 13'b0000100000000,
		ST_REL_BM   = 13'b0001000000000,
		ST_XL_RD    = 13'b0010000000000,
		ST_XL_EVAL  = 13'b0100000000000,
		ST_FIN      = 13'b1000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   kill_q, kill_nxt;

	assign in_stall = (state_q != ST_IDLE);

	// Sequence one operation
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		kill_nxt  = kill_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.func)
					pmfa_pkg::FN_CREATE: begin
						if (!sts.slot_free) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_NOSLOT;
							state_nxt       = ST_FIN;
						end else if (sts.too_big) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_SEGV;
							state_nxt       = ST_FIN;
						end else if (!sts.frames_ok) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_NOMEM;
							state_nxt       = ST_FIN;
						end else begin
							cmd.claim       = 1'b1;
							cmd.cursor_zero = 1'b1;
							cmd.seg_first   = 1'b1;
							state_nxt       = ST_MAP_RD;
						end
					end
					pmfa_pkg::FN_EXIT: begin
						if (!sts.have) begin
							state_nxt = ST_FIN;
						end else begin
							cmd.walk_kill = 1'b1;
							kill_nxt      = 1'b1;
							state_nxt     = ST_REL_RD;
						end
					end
					pmfa_pkg::FN_ALLOC, pmfa_pkg::FN_DEALLOC: begin
						if (!sts.have) begin
							state_nxt = ST_FIN;
						end else if (sts.range_bad) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_SEGV;
							cmd.walk_kill   = 1'b1;
							kill_nxt        = 1'b1;
							state_nxt       = ST_REL_RD;
						end else begin
							cmd.walk_range = 1'b1;
							state_nxt      = ST_CHK_RD;
						end
					end
					pmfa_pkg::FN_READ, pmfa_pkg::FN_WRITE: begin
						if (!sts.have) begin
							state_nxt = ST_FIN;
						end else if (!sts.page_ok) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_SEGV;
							cmd.walk_kill   = 1'b1;
							kill_nxt        = 1'b1;
							state_nxt       = ST_REL_RD;
						end else begin
							cmd.walk_range = 1'b1;
							state_nxt      = ST_XL_RD;
						end
					end
					default: state_nxt = ST_FIN;
				endcase
			end
			// Scan the range for present pages
			ST_CHK_RD: begin
				if (sts.walk_done) begin
					if (sts.func == pmfa_pkg::FN_ALLOC) begin
						if (!sts.frames_ok) begin
							cmd.set_status  = 1'b1;
							cmd.status_code = pmfa_pkg::STS_NOMEM;
							state_nxt       = ST_FIN;
						end else begin
							cmd.walk_range  = 1'b1;
							cmd.cursor_zero = 1'b1;
							state_nxt       = ST_MAP_RD;
						end
					end else begin
						cmd.walk_range = 1'b1;
						kill_nxt       = 1'b0;
						state_nxt      = ST_REL_RD;
					end
				end else begin
					cmd.pt_rd = 1'b1;
					state_nxt = ST_CHK_EVAL;
				end
			end
			ST_CHK_EVAL: begin
				if (sts.pte_present == (sts.func == pmfa_pkg::FN_ALLOC)) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = pmfa_pkg::STS_SEGV;
					cmd.walk_kill   = 1'b1;
					kill_nxt        = 1'b1;
					state_nxt       = ST_REL_RD;
				end else begin
					cmd.walk_inc = 1'b1;
					state_nxt    = ST_CHK_RD;
				end
			end
			// Map pages, one free frame each
			ST_MAP_RD: begin
				if (sts.walk_done) begin
					if (sts.func == pmfa_pkg::FN_CREATE && !sts.seg_last) begin
						cmd.seg_next = 1'b1;
					end else begin
						state_nxt = ST_FIN;
					end
				end else begin
					cmd.bm_rd_cur = 1'b1;
					state_nxt     = ST_MAP_EVAL;
				end
			end
			ST_MAP_EVAL: begin
				cmd.cursor_inc = 1'b1;
				if (!sts.bm_bit) begin
					cmd.map_wr   = 1'b1;
					cmd.walk_inc = 1'b1;
				end
				state_nxt = ST_MAP_RD;
			end
			// Unmap pages and release their frames
			ST_REL_RD: begin
				if (sts.walk_done) begin
					if (kill_q) cmd.kill = 1'b1;
					else cmd.cnt_sub = 1'b1;
					state_nxt = ST_FIN;
				end else begin
					cmd.pt_rd = 1'b1;
					state_nxt = ST_REL_PTE;
				end
			end
			ST_REL_PTE: begin
				cmd.pt_zero = 1'b1;
				if (sts.pte_present && sts.idx_ok) begin
					cmd.bm_rd_idx = 1'b1;
					state_nxt     = ST_REL_BM;
				end else begin
					cmd.walk_inc = 1'b1;
					state_nxt    = ST_REL_RD;
				end
			end
			ST_REL_BM: begin
				if (sts.bm_bit) cmd.bm_clr = 1'b1;
				cmd.walk_inc = 1'b1;
				state_nxt    = ST_REL_RD;
			end
			// Translate one address
			ST_XL_RD: begin
				cmd.pt_rd = 1'b1;
				state_nxt = ST_XL_EVAL;
			end
			ST_XL_EVAL: begin
				if (sts.pte_present && sts.perm_ok) begin
					cmd.set_access = 1'b1;
					state_nxt      = ST_FIN;
				end else begin
					cmd.set_status  = 1'b1;
					cmd.status_code = pmfa_pkg::STS_SEGV;
					cmd.walk_kill   = 1'b1;
					kill_nxt        = 1'b1;
					state_nxt       = ST_REL_RD;
				end
			end
			// Hand the result to the output register
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			kill_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			kill_q  <= kill_nxt;
		end
	end

endmodule

// ===== hw/rtl/pmfa_dp.sv =====
module pmfa_dp #(
	parameter int PROCESS_SLOTS     = pmfa_pkg::PROCESS_SLOTS_DEF,
	parameter int PAGES_PER_PROCESS = pmfa_pkg::PAGES_PER_PROCESS_DEF,
	parameter int USABLE_FRAMES     = pmfa_pkg::USABLE_FRAMES_DEF,
	parameter int PAGE_BYTES        = pmfa_pkg::PAGE_BYTES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pmfa_pkg::cmd_t                    cmd,
	output pmfa_pkg::sts_t                    sts,
	input  logic [pmfa_pkg::FUNC_W-1:0]       func,
	input  logic [pmfa_pkg::PID_W-1:0]        pid,
	input  logic [pmfa_pkg::VADDR_W-1:0]      vaddr,
	input  logic [pmfa_pkg::COUNT_W-1:0]      page_count,
	input  logic [pmfa_pkg::PROT_W-1:0]       prot_flags,
	input  logic [pmfa_pkg::COUNT_W-1:0]      code_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]      rodata_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]      rwdata_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]      stack_pages,
	input  logic [pmfa_pkg::BYTE_W-1:0]       write_byte,
	input  logic                              cfg_we,
	input  logic [pmfa_pkg::FRAME_W-1:0]      cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pmfa_pkg::STATUS_W-1:0]     status,
	output logic [pmfa_pkg::PID_W-1:0]        pid_out,
	output logic [pmfa_pkg::PHYS_W-1:0]       phys_addr,
	output logic                              mem_write,
	output logic                              mem_read,
	output logic [pmfa_pkg::BYTE_W-1:0]       write_data,
	output logic [pmfa_pkg::COUNT_W-1:0]      mapped_count
);

	localparam int SLOT_W   = (PROCESS_SLOTS > 1) ? $clog2(PROCESS_SLOTS) : 1;
	localparam int PT_DEPTH = PROCESS_SLOTS * PAGES_PER_PROCESS;
	localparam int PT_AW    = $clog2(PT_DEPTH);
	localparam int PW       = $clog2(PAGES_PER_PROCESS + 1);
	localparam int BM_AW    = $clog2(USABLE_FRAMES);
	localparam int CNT_W    = $clog2(USABLE_FRAMES + 1);
	localparam int PG_SH    = $clog2(PAGE_BYTES);
	localparam int VP_W     = pmfa_pkg::VADDR_W - PG_SH;
	localparam int CLR_N    = (PT_DEPTH > USABLE_FRAMES) ? PT_DEPTH : USABLE_FRAMES;
	localparam int CLR_W    = $clog2(CLR_N);
	localparam int BW       = pmfa_pkg::BOUND_W;
	localparam int RS_W     = ((VP_W > BW) ? VP_W : BW) + 1;
	localparam int NEED_W   = ((CNT_W > BW) ? CNT_W : BW) + 1;
	localparam int FW       = pmfa_pkg::FRAME_W;

	// Operation registers
	logic [pmfa_pkg::FUNC_W-1:0]   func_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [VP_W-1:0]               page_q;
	logic [PG_SH-1:0]              off_q;
	logic [pmfa_pkg::COUNT_W-1:0]  cnt_q, nc_q, nr_q, nw_q, ns_q;
	logic [pmfa_pkg::PROT_W-1:0]   prot_q;
	logic [pmfa_pkg::BYTE_W-1:0]   wbyte_q;
	logic                          have_q;
	logic [pmfa_pkg::PID_W-1:0]    pid_res_q;
	logic [pmfa_pkg::STATUS_W-1:0] status_q;
	logic [pmfa_pkg::PHYS_W-1:0]   phys_q;
	logic                          mr_q, mw_q;
	logic [pmfa_pkg::BYTE_W-1:0]   wd_q;

	// Walk state
	logic [PW-1:0]                 walk_q, end_q;
	logic [1:0]                    seg_q;
	logic [CNT_W-1:0]              cur_q;
	logic [pmfa_pkg::PTE_W-1:0]    pte_rd_q;
	logic                          bm_rd_q;

	// Tables
	logic                          busy_q [PROCESS_SLOTS];
	logic [pmfa_pkg::COUNT_W-1:0]  pcnt_q [PROCESS_SLOTS];
	logic [CNT_W-1:0]              used_q;
	logic [FW-1:0]                 frame_base_q;
	logic [CLR_W-1:0]              clr_q;
	logic [pmfa_pkg::PTE_W-1:0]    pt_mem [PT_DEPTH];
	logic                          bm_mem [USABLE_FRAMES];

	// Output register
	logic                          out_valid_q;
	logic [pmfa_pkg::STATUS_W-1:0] o_status_q;
	logic [pmfa_pkg::PID_W-1:0]    o_pid_q;
	logic [pmfa_pkg::PHYS_W-1:0]   o_phys_q;
	logic                          o_mw_q, o_mr_q;
	logic [pmfa_pkg::BYTE_W-1:0]   o_wd_q;
	logic [pmfa_pkg::COUNT_W-1:0]  o_mapped_q;

	// Combinational
	logic                          pid_in_rng, slot_ok_in;
	logic [SLOT_W-1:0]             free_idx;
	logic                          slot_free;
	logic [BW-1:0]                 b1, b2, b3, total, stk_lo, seg_lo, seg_hi;
	logic [1:0]                    nxt_seg;
	logic [RS_W-1:0]               range_end;
	logic [NEED_W-1:0]             need, free_n;
	logic [FW-1:0]                 rel_idx, frame_new;
	logic                          idx_ok;
	logic [pmfa_pkg::PROT_W-1:0]   map_flags, seg_flag, need_bit;
	logic [PT_AW-1:0]              pt_addr;
	logic [pmfa_pkg::PTE_W-1:0]    pt_wdata;
	logic                          pt_we, clr_pt, clr_bm;
	logic [BM_AW-1:0]              bm_addr;
	logic                          bm_we, bm_rd;

	assign pid_in_rng = ({1'b0, pid} < (pmfa_pkg::PID_W + 1)'(PROCESS_SLOTS));
	assign slot_ok_in = pid_in_rng && busy_q[SLOT_W'(pid)];

	// Find the lowest free slot
	always_comb begin
		free_idx  = '0;
		slot_free = 1'b0;
		for (int i = PROCESS_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				slot_free = 1'b1;
				free_idx  = SLOT_W'(i);
			end
		end
	end

	// Segment bounds of the create layout
	assign b1      = BW'(nc_q);
	assign b2      = b1 + BW'(nr_q);
	assign b3      = b2 + BW'(nw_q);
	assign total   = b3 + BW'(ns_q);
	assign stk_lo  = BW'(PAGES_PER_PROCESS) - BW'(ns_q);
	assign nxt_seg = cmd.seg_first ? 2'd0 : seg_q + 2'd1;

	always_comb begin
		case (nxt_seg)
			2'd0: begin
				seg_lo = '0;
				seg_hi = b1;
			end
			2'd1: begin
				seg_lo = b1;
				seg_hi = b2;
			end
			2'd2: begin
				seg_lo = b2;
				seg_hi = b3;
			end
			default: begin
				seg_lo = stk_lo;
				seg_hi = BW'(PAGES_PER_PROCESS);
			end
		endcase
	end

	always_comb begin
		case (seg_q)
			2'd0:    seg_flag = pmfa_pkg::FLAG_CODE;
			2'd1:    seg_flag = pmfa_pkg::FLAG_RO;
			default: seg_flag = pmfa_pkg::FLAG_RW;
		endcase
	end

	assign map_flags = (func_q == pmfa_pkg::FN_CREATE) ? seg_flag : prot_q;
	assign range_end = RS_W'(page_q) + RS_W'(cnt_q);
	assign need      = (func_q == pmfa_pkg::FN_CREATE) ? NEED_W'(total) : NEED_W'(cnt_q);
	assign free_n    = NEED_W'(USABLE_FRAMES) - NEED_W'(used_q);
	assign need_bit  = (func_q == pmfa_pkg::FN_READ) ? pmfa_pkg::FLAG_R : pmfa_pkg::FLAG_W;

	// Frame index of a table entry, relative to the base
	assign rel_idx   = pte_rd_q[pmfa_pkg::PTE_W-1:4] - frame_base_q;
	assign idx_ok    = ({1'b0, rel_idx} < (FW + 1)'(USABLE_FRAMES));
	assign frame_new = FW'(cur_q) + frame_base_q;

	// Memory ports
	assign clr_pt   = cmd.clr_step && ({1'b0, clr_q} < (CLR_W + 1)'(PT_DEPTH));
	assign clr_bm   = cmd.clr_step && ({1'b0, clr_q} < (CLR_W + 1)'(USABLE_FRAMES));
	assign pt_addr  = cmd.clr_step ? clr_q[PT_AW-1:0]
	                : PT_AW'(slot_q) * PT_AW'(PAGES_PER_PROCESS) + PT_AW'(walk_q);
	assign pt_wdata = cmd.map_wr ? {frame_new, 1'b1, map_flags} : '0;
	assign pt_we    = clr_pt || cmd.pt_zero || cmd.map_wr;
	assign bm_addr  = cmd.clr_step ? clr_q[BM_AW-1:0]
	                : (cmd.map_wr || cmd.bm_rd_cur) ? cur_q[BM_AW-1:0] : rel_idx[BM_AW-1:0];
	assign bm_we    = clr_bm || cmd.map_wr || cmd.bm_clr;
	assign bm_rd    = cmd.bm_rd_cur || cmd.bm_rd_idx;

	always_ff @(posedge clk) begin
		if (pt_we) pt_mem[pt_addr] <= pt_wdata;
		if (cmd.pt_rd) pte_rd_q <= pt_mem[pt_addr];
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_addr] <= cmd.map_wr;
		if (bm_rd) bm_rd_q <= bm_mem[bm_addr];
	end

	// Capture the item and track the result fields
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q    <= func;
			slot_q    <= SLOT_W'(pid);
			page_q    <= vaddr[pmfa_pkg::VADDR_W-1:PG_SH];
			off_q     <= vaddr[PG_SH-1:0];
			cnt_q     <= page_count;
			prot_q    <= prot_flags;
			nc_q      <= code_pages;
			nr_q      <= rodata_pages;
			nw_q      <= rwdata_pages;
			ns_q      <= stack_pages;
			wbyte_q   <= write_byte;
			pid_res_q <= (func == pmfa_pkg::FN_CREATE) ? '0 : pid;
			phys_q    <= '0;
			mr_q      <= 1'b0;
			mw_q      <= 1'b0;
			wd_q      <= '0;
			if (func == pmfa_pkg::FN_CREATE) begin
				have_q   <= 1'b0;
				status_q <= pmfa_pkg::STS_OK;
			end else if (func > pmfa_pkg::FN_WRITE) begin
				have_q   <= pid_in_rng;
				status_q <= pmfa_pkg::STS_OK;
			end else begin
				have_q   <= slot_ok_in;
				status_q <= slot_ok_in ? pmfa_pkg::STS_OK : pmfa_pkg::STS_SEGV;
			end
		end else begin
			if (cmd.claim) begin
				slot_q    <= free_idx;
				pid_res_q <= pmfa_pkg::PID_W'(free_idx);
				have_q    <= 1'b1;
			end
			if (cmd.set_status) status_q <= cmd.status_code;
			if (cmd.set_access) begin
				phys_q <= pmfa_pkg::PHYS_W'({pte_rd_q[pmfa_pkg::PTE_W-1:4], off_q});
				mr_q   <= (func_q == pmfa_pkg::FN_READ);
				mw_q   <= (func_q == pmfa_pkg::FN_WRITE);
				wd_q   <= (func_q == pmfa_pkg::FN_WRITE) ? wbyte_q : '0;
			end
		end
	end

	// Advance the page walk and the frame cursor
	always_ff @(posedge clk) begin
		if (cmd.walk_kill) begin
			walk_q <= '0;
			end_q  <= PW'(PAGES_PER_PROCESS);
		end else if (cmd.walk_range) begin
			walk_q <= PW'(page_q);
			end_q  <= PW'(range_end);
		end else if (cmd.seg_first || cmd.seg_next) begin
			seg_q  <= nxt_seg;
			walk_q <= PW'(seg_lo);
			end_q  <= PW'(seg_hi);
		end else if (cmd.walk_inc) begin
			walk_q <= walk_q + PW'(1);
		end
		if (cmd.cursor_zero) cur_q <= '0;
		else if (cmd.cursor_inc) cur_q <= cur_q + CNT_W'(1);
	end

	// Slot table, frame count, base register, clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PROCESS_SLOTS; i++) begin
				busy_q[i] <= 1'b0;
				pcnt_q[i] <= '0;
			end
			used_q       <= '0;
			frame_base_q <= pmfa_pkg::FRAME_BASE_RST;
			clr_q        <= '0;
		end else begin
			if (cmd.claim) busy_q[free_idx] <= 1'b1;
			if (cmd.kill) begin
				busy_q[slot_q] <= 1'b0;
				pcnt_q[slot_q] <= '0;
			end else if (cmd.map_wr) begin
				pcnt_q[slot_q] <= pcnt_q[slot_q] + pmfa_pkg::COUNT_W'(1);
			end else if (cmd.cnt_sub) begin
				pcnt_q[slot_q] <= pcnt_q[slot_q] - cnt_q;
			end
			if (cmd.map_wr) used_q <= used_q + CNT_W'(1);
			else if (cmd.bm_clr) used_q <= used_q - CNT_W'(1);
			if (cfg_we) frame_base_q <= cfg_wdata;
			if (cmd.clr_step) clr_q <= clr_q + CLR_W'(1);
		end
	end

	// Output register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status_q <= status_q;
			o_pid_q    <= pid_res_q;
			o_phys_q   <= phys_q;
			o_mw_q     <= mw_q;
			o_mr_q     <= mr_q;
			o_wd_q     <= wd_q;
			o_mapped_q <= have_q ? pcnt_q[slot_q] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = o_status_q;
	assign pid_out      = o_pid_q;
	assign phys_addr    = o_phys_q;
	assign mem_write    = o_mw_q;
	assign mem_read     = o_mr_q;
	assign write_data   = o_wd_q;
	assign mapped_count = o_mapped_q;

	// Status to the controller
	always_comb begin
		sts             = '0;
		sts.func        = func_q;
		sts.have        = have_q;
		sts.clr_last    = (clr_q == CLR_W'(CLR_N - 1));
		sts.walk_done   = (walk_q == end_q);
		sts.seg_last    = (seg_q == 2'd3);
		sts.slot_free   = slot_free;
		sts.too_big     = (total > BW'(PAGES_PER_PROCESS));
		sts.frames_ok   = (need <= free_n);
		sts.range_bad   = (range_end > RS_W'(PAGES_PER_PROCESS));
		sts.page_ok     = (RS_W'(page_q) < RS_W'(PAGES_PER_PROCESS));
		sts.pte_present = pte_rd_q[3];
		sts.perm_ok     = ((pte_rd_q[2:0] & need_bit) != '0);
		sts.idx_ok      = idx_ok;
		sts.bm_bit      = bm_rd_q;
		sts.out_busy    = out_valid_q && out_stall;
	end

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, used_q} <= (CNT_W + 1)'(USABLE_FRAMES))
		else $error("frame use count above frame total");
	a_map_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.map_wr |-> !bm_rd_q && busy_q[slot_q])
		else $error("mapping onto a used frame or a free slot");
	a_rel_used: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bm_clr |-> bm_rd_q && (used_q != '0))
		else $error("releasing a frame that is not in use");
	a_load_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result overwritten while still held");
`endif

endmodule

// ===== hw/rtl/paged_mmu_frame_allocator_top.sv =====
// Channel   Handshake               Payload
// in        in_valid / in_stall     func pid vaddr page_count prot_flags code_pages
//                                   rodata_pages rwdata_pages stack_pages write_byte
// out       out_valid / out_stall   status pid_out phys_addr mem_write mem_read
//                                   write_data mapped_count
// cfg       cfg_we                  cfg_wdata (frame_base)
//
// One item at a time. Read and write: after accept the item passes the dispatch,
// table read, check and finish states; finish loads the result when the output
// register is free. Exit and fault kills walk every page entry of the slot; each
// entry is read and cleared, and a frame it releases is cleared in the bitmap.
// Allocate and deallocate check each page; a mapped page scans the bitmap for a
// free frame. After reset, clearing max(PROCESS_SLOTS * PAGES_PER_PROCESS,
// USABLE_FRAMES) entries (16384 by default) keeps in_stall high.
// A finished result waits in the output register while the next item is taken.
module paged_mmu_frame_allocator_top #(
	parameter int PROCESS_SLOTS     = pmfa_pkg::PROCESS_SLOTS_DEF,
	parameter int PAGES_PER_PROCESS = pmfa_pkg::PAGES_PER_PROCESS_DEF,
	parameter int USABLE_FRAMES     = pmfa_pkg::USABLE_FRAMES_DEF,
	parameter int PAGE_BYTES        = pmfa_pkg::PAGE_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pmfa_pkg::FUNC_W-1:0]   func,
	input  logic [pmfa_pkg::PID_W-1:0]    pid,
	input  logic [pmfa_pkg::VADDR_W-1:0]  vaddr,
	input  logic [pmfa_pkg::COUNT_W-1:0]  page_count,
	input  logic [pmfa_pkg::PROT_W-1:0]   prot_flags,
	input  logic [pmfa_pkg::COUNT_W-1:0]  code_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]  rodata_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]  rwdata_pages,
	input  logic [pmfa_pkg::COUNT_W-1:0]  stack_pages,
	input  logic [pmfa_pkg::BYTE_W-1:0]   write_byte,
	input  logic                          cfg_we,
	input  logic [pmfa_pkg::FRAME_W-1:0]  cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pmfa_pkg::STATUS_W-1:0] status,
	output logic [pmfa_pkg::PID_W-1:0]    pid_out,
	output logic [pmfa_pkg::PHYS_W-1:0]   phys_addr,
	output logic                          mem_write,
	output logic                          mem_read,
	output logic [pmfa_pkg::BYTE_W-1:0]   write_data,
	output logic [pmfa_pkg::COUNT_W-1:0]  mapped_count
);

	pmfa_pkg::cmd_t cmd;
	pmfa_pkg::sts_t sts;

	pmfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	pmfa_dp #(
		.PROCESS_SLOTS     (PROCESS_SLOTS),
		.PAGES_PER_PROCESS (PAGES_PER_PROCESS),
		.USABLE_FRAMES     (USABLE_FRAMES),
		.PAGE_BYTES        (PAGE_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.pid          (pid),
		.vaddr        (vaddr),
		.page_count   (page_count),
		.prot_flags   (prot_flags),
		.code_pages   (code_pages),
		.rodata_pages (rodata_pages),
		.rwdata_pages (rwdata_pages),
		.stack_pages  (stack_pages),
		.write_byte   (write_byte),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.pid_out      (pid_out),
		.phys_addr    (phys_addr),
		.mem_write    (mem_write),
		.mem_read     (mem_read),
		.write_data   (write_data),
		.mapped_count (mapped_count)
	);

endmodule
